FILE: design/lpr_pkg.sv
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared widths, reset values and control types of the page replacement unit.
// ----------------------------------------------------------------------------
package lpr_pkg;

  localparam int PAGE_W         = 16;
  localparam int FRAME_COUNT_W  = 4;
  localparam int FRAME_SLOT_W   = 3;
  localparam int TOTAL_W        = 32;
  localparam int MAX_FRAMES_DEF = 8;

  localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 4'd8;

  // flags carried by the search token along the cell chain
  typedef struct packed {
    logic hit;
    logic free;
  } srch_flags_t;

  // update command broadcast to every cell
  typedef struct packed {
    logic flush;
    logic apply;
    logic write;
    logic age_all;
  } upd_cmd_t;

endpackage

FILE: design/lpr_cell.sv
// ----------------------------------------------------------------------------
// lpr_cell
// One page frame: holds page, valid and recency rank, refines the search
// token from its left neighbor and registers it for its right neighbor.
// ----------------------------------------------------------------------------
module lpr_cell import lpr_pkg::*; #(
  parameter int IDX_W    = 3,
  parameter int CNT_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  nf,
  input  logic [PAGE_W-1:0] key,
  input  srch_flags_t       fl_in,
  input  logic [IDX_W-1:0]  hit_slot_in,
  input  logic [IDX_W-1:0]  hit_rank_in,
  input  logic [IDX_W-1:0]  free_slot_in,
  input  logic [IDX_W-1:0]  ev_slot_in,
  input  logic [IDX_W-1:0]  ev_rank_in,
  input  logic [PAGE_W-1:0] ev_page_in,
  output srch_flags_t       fl_out,
  output logic [IDX_W-1:0]  hit_slot_out,
  output logic [IDX_W-1:0]  hit_rank_out,
  output logic [IDX_W-1:0]  free_slot_out,
  output logic [IDX_W-1:0]  ev_slot_out,
  output logic [IDX_W-1:0]  ev_rank_out,
  output logic [PAGE_W-1:0] ev_page_out,
  input  upd_cmd_t          cmd,
  input  logic [IDX_W-1:0]  cmd_slot,
  input  logic [IDX_W-1:0]  cmd_limit,
  input  logic [PAGE_W-1:0] cmd_page,
  output logic              vld
);

  localparam logic [IDX_W-1:0] MY_SLOT = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(CELL_IDX);

  logic [PAGE_W-1:0] page_r;
  logic [IDX_W-1:0]  rank;
  logic              en;
  logic              take_hit;
  logic              take_free;
  logic              take_ev;

  assign en        = MY_CNT < nf;
  assign take_hit  = en && vld && (page_r == key) && !fl_in.hit;
  assign take_free = en && !vld && !fl_in.free;
  assign take_ev   = en && (rank >= ev_rank_in);

  // search token stage
  always_ff @(posedge clk) begin
    fl_out.hit    <= fl_in.hit | take_hit;
    fl_out.free   <= fl_in.free | take_free;
    hit_slot_out  <= take_hit ? MY_SLOT : hit_slot_in;
    hit_rank_out  <= take_hit ? rank : hit_rank_in;
    free_slot_out <= take_free ? MY_SLOT : free_slot_in;
    ev_slot_out   <= take_ev ? MY_SLOT : ev_slot_in;
    ev_rank_out   <= take_ev ? rank : ev_rank_in;
    ev_page_out   <= take_ev ? page_r : ev_page_in;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (rst || cmd.flush) begin
      vld  <= 1'b0;
      rank <= '0;
    end else if (cmd.apply) begin
      if (cmd_slot == MY_SLOT) begin
        rank <= '0;
        if (cmd.write) begin
          vld <= 1'b1;
        end
      end else if (vld && (cmd.age_all || rank < cmd_limit)) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply && cmd.write && cmd_slot == MY_SLOT) begin
      page_r <= cmd_page;
    end
  end

endmodule

FILE: design/lru_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit
// LRU page replacement over a chain of frame cells with hit and miss totals.
// ----------------------------------------------------------------------------
// result: registered in the update state, after the search token has walked
//   the cell chain one frame per cycle; the update waits while the result
//   register is blocked, and no new beat is accepted until the unit is idle
// reset: all frames empty, frame_count 8, totals zero
// a frame_count write empties every frame and keeps the totals
module lru_page_replacement_unit import lpr_pkg::*; #(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_wr_en,
  input  logic [FRAME_COUNT_W-1:0] cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [PAGE_W-1:0]        page,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     hit,
  output logic [FRAME_SLOT_W-1:0]  frame_slot,
  output logic                     evicted_valid,
  output logic [PAGE_W-1:0]        evicted_page,
  output logic [TOTAL_W-1:0]       miss_total,
  output logic [TOTAL_W-1:0]       hit_total
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int LAST  = MAX_FRAMES;
  localparam logic [IDX_W-1:0] CNT_END = IDX_W'(MAX_FRAMES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SRCH, ST_UPD} state_t;

  state_t                   state;
  logic [IDX_W-1:0]         cnt;
  logic [PAGE_W-1:0]        page_q;
  logic [FRAME_COUNT_W-1:0] frame_count;
  logic [CNT_W-1:0]         nf;
  logic [TOTAL_W-1:0]       ref_cnt;
  logic [TOTAL_W-1:0]       fault_cnt;
  logic [TOTAL_W-1:0]       ref_next;
  logic [TOTAL_W-1:0]       fault_next;
  logic                     out_free;

  srch_flags_t       fl [MAX_FRAMES+1];
  logic [IDX_W-1:0]  hs [MAX_FRAMES+1];
  logic [IDX_W-1:0]  hr [MAX_FRAMES+1];
  logic [IDX_W-1:0]  fs [MAX_FRAMES+1];
  logic [IDX_W-1:0]  es [MAX_FRAMES+1];
  logic [IDX_W-1:0]  er [MAX_FRAMES+1];
  logic [PAGE_W-1:0] ep [MAX_FRAMES+1];
  logic [MAX_FRAMES-1:0] vld_vec;

  upd_cmd_t          cmd;
  logic [IDX_W-1:0]  cmd_slot;
  logic [IDX_W-1:0]  cmd_limit;
  logic              evict;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    if (frame_count == '0) begin
      nf = CNT_W'(1);
    end else if (int'(frame_count) > MAX_FRAMES) begin
      nf = CNT_W'(MAX_FRAMES);
    end else begin
      nf = CNT_W'(frame_count);
    end
  end

  // head of the chain
  assign fl[0] = '0;
  assign hs[0] = '0;
  assign hr[0] = '0;
  assign fs[0] = '0;
  assign es[0] = '0;
  assign er[0] = '0;
  assign ep[0] = '0;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    lpr_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .nf            (nf),
      .key           (page_q),
      .fl_in         (fl[i]),
      .hit_slot_in   (hs[i]),
      .hit_rank_in   (hr[i]),
      .free_slot_in  (fs[i]),
      .ev_slot_in    (es[i]),
      .ev_rank_in    (er[i]),
      .ev_page_in    (ep[i]),
      .fl_out        (fl[i+1]),
      .hit_slot_out  (hs[i+1]),
      .hit_rank_out  (hr[i+1]),
      .free_slot_out (fs[i+1]),
      .ev_slot_out   (es[i+1]),
      .ev_rank_out   (er[i+1]),
      .ev_page_out   (ep[i+1]),
      .cmd           (cmd),
      .cmd_slot      (cmd_slot),
      .cmd_limit     (cmd_limit),
      .cmd_page      (page_q),
      .vld           (vld_vec[i])
    );
  end

  // decision from the token leaving the last cell
  always_comb begin
    cmd.flush = cfg_wr_en;
    cmd.apply = (state == ST_UPD) && out_free;
    if (fl[LAST].hit) begin
      cmd_slot    = hs[LAST];
      cmd_limit   = hr[LAST];
      cmd.write   = 1'b0;
      cmd.age_all = 1'b0;
      evict       = 1'b0;
    end else if (fl[LAST].free) begin
      cmd_slot    = fs[LAST];
      cmd_limit   = '0;
      cmd.write   = 1'b1;
      cmd.age_all = 1'b1;
      evict       = 1'b0;
    end else begin
      cmd_slot    = es[LAST];
      cmd_limit   = er[LAST];
      cmd.write   = 1'b1;
      cmd.age_all = 1'b0;
      evict       = 1'b1;
    end
  end

  // saturating totals
  always_comb begin
    ref_next   = ref_cnt;
    fault_next = fault_cnt;
    if (ref_cnt != '1) begin
      ref_next = ref_cnt + 1'b1;
      if (!fl[LAST].hit) begin
        fault_next = fault_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      cnt         <= '0;
      out_valid   <= 1'b0;
      frame_count <= FRAME_COUNT_RESET;
      ref_cnt     <= '0;
      fault_cnt   <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && !cmd.apply) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            page_q <= page;
            cnt    <= '0;
            state  <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_END) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            ref_cnt       <= ref_next;
            fault_cnt     <= fault_next;
            out_valid     <= 1'b1;
            hit           <= fl[LAST].hit;
            frame_slot    <= FRAME_SLOT_W'(cmd_slot);
            evicted_valid <= evict;
            evicted_page  <= evict ? ep[LAST] : '0;
            miss_total    <= fault_next;
            hit_total     <= ref_next - fault_next;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_apply_free: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |-> (!out_valid || !out_stall))
    else $error("update applied while result register blocked");

  a_result_up: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid)
    else $error("update without result beat");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && evicted_valid))
    else $error("hit reported with eviction");

  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !fl[LAST].hit && !fl[LAST].free)
      |-> ($countones(vld_vec) == int'(nf)))
    else $error("eviction while a frame is free");

  a_fault_le_ref: assert property (@(posedge clk) disable iff (rst)
    fault_cnt <= ref_cnt)
    else $error("fault total above reference total");

endmodule

FILE: dv/lru_page_replacement_unit_test.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_unit_test
// Drives page references through the LRU page replacement unit with random
// bursts, gaps and output stalls, predicts every outcome with an independent
// frame and recency model, and checks each result beat in order. Frame count
// is rewritten between phases, including zero, the maximum and values above it.
// ----------------------------------------------------------------------------
module lru_page_replacement_unit_test;
  import lpr_pkg::*;

  typedef struct packed {
    logic                    hit;
    logic [FRAME_SLOT_W-1:0] slot;
    logic                    ev_valid;
    logic [PAGE_W-1:0]       ev_page;
    logic [TOTAL_W-1:0]      misses;
    logic [TOTAL_W-1:0]      hits;
  } outcome_t;

  class lru_scoreboard;
    logic [FRAME_COUNT_W-1:0] frame_count;
    logic [PAGE_W-1:0]        pages[MAX_FRAMES_DEF];
    bit                       valid[MAX_FRAMES_DEF];
    logic [FRAME_SLOT_W-1:0]  rank[MAX_FRAMES_DEF];
    logic [TOTAL_W-1:0]       faults;
    logic [TOTAL_W-1:0]       refs;
    outcome_t                 expected_outcomes[$];
    int                       mismatches;

    function new();
      frame_count = FRAME_COUNT_RESET;
      faults = '0;
      refs = '0;
      mismatches = 0;
      empty_frames();
    endfunction

    function void empty_frames();
      for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
        pages[i] = '0;
        valid[i] = 1'b0;
        rank[i] = '0;
      end
    endfunction

    function void set_frame_count(logic [FRAME_COUNT_W-1:0] v);
      frame_count = v;
      empty_frames();
    endfunction

    function int pending();
      return expected_outcomes.size();
    endfunction

    // frame f becomes most recent, younger valid frames below limit age by one
    function void make_recent(int unsigned f, int unsigned limit);
      for (int i = 0; i < MAX_FRAMES_DEF; i++) begin
        if (i != f && valid[i] && rank[i] < limit) rank[i] = rank[i] + 1'b1;
      end
      rank[f] = '0;
    endfunction

    function outcome_t predict_access(logic [PAGE_W-1:0] p);
      outcome_t    o;
      int unsigned nf;
      int unsigned slot;
      int unsigned worst;
      bit          found;
      bit          have_free;
      o = '0;
      slot = 0;
      found = 1'b0;
      have_free = 1'b0;
      if (frame_count == 0) nf = 1;
      else if (frame_count > MAX_FRAMES_DEF) nf = MAX_FRAMES_DEF;
      else nf = 32'(frame_count);
      for (int i = 0; i < nf; i++) begin
        if (!found && valid[i] && pages[i] == p) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        o.hit = 1'b1;
        make_recent(slot, 32'(rank[slot]));
      end else begin
        for (int i = 0; i < nf; i++) begin
          if (!have_free && !valid[i]) begin
            slot = i;
            have_free = 1'b1;
          end
        end
        if (have_free) begin
          valid[slot] = 1'b1;
          pages[slot] = p;
          make_recent(slot, MAX_FRAMES_DEF + 1);
        end else begin
          worst = 0;
          for (int i = 0; i < nf; i++) begin
            if (rank[i] >= worst) begin
              worst = 32'(rank[i]);
              slot = i;
            end
          end
          o.ev_valid = 1'b1;
          o.ev_page = pages[slot];
          pages[slot] = p;
          make_recent(slot, worst);
        end
      end
      if (refs != '1) begin
        refs = refs + 1'b1;
        if (!o.hit) faults = faults + 1'b1;
      end
      o.slot = slot[FRAME_SLOT_W-1:0];
      o.misses = faults;
      o.hits = refs - faults;
      return o;
    endfunction

    function void note_reference(logic [PAGE_W-1:0] p);
      expected_outcomes.insert(expected_outcomes.size(), predict_access(p));
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t exp;
      if (expected_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: hit=%0d slot=%0d ev=%0d/%h miss=%0d hit_total=%0d",
                   got.hit, got.slot, got.ev_valid, got.ev_page, got.misses, got.hits);
        return;
      end
      exp = expected_outcomes.pop_front();
      if (got.hit !== exp.hit || got.slot !== exp.slot || got.ev_valid !== exp.ev_valid ||
          got.ev_page !== exp.ev_page || got.misses !== exp.misses ||
          got.hits !== exp.hits) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch exp: hit=%0d slot=%0d ev=%0d/%h miss=%0d hit_total=%0d",
                   exp.hit, exp.slot, exp.ev_valid, exp.ev_page, exp.misses, exp.hits);
          $display("         got: hit=%0d slot=%0d ev=%0d/%h miss=%0d hit_total=%0d",
                   got.hit, got.slot, got.ev_valid, got.ev_page, got.misses, got.hits);
        end
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [FRAME_COUNT_W-1:0] cfg_wr_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [PAGE_W-1:0]        page = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     hit;
  logic [FRAME_SLOT_W-1:0]  frame_slot;
  logic                     evicted_valid;
  logic [PAGE_W-1:0]        evicted_page;
  logic [TOTAL_W-1:0]       miss_total;
  logic [TOTAL_W-1:0]       hit_total;

  lru_scoreboard sb = new();
  int            stall_pct = 0;
  int            stall_run = 0;

  lru_page_replacement_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .page          (page),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_slot    (frame_slot),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .miss_total    (miss_total),
    .hit_total     (hit_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, switching between calm and busy stretches
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_run == 0) begin
        case ($urandom_range(4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 50;
          default: stall_pct = 85;
        endcase
        stall_run = $urandom_range(120, 10);
      end else begin
        stall_run--;
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_reference(page);
      if (out_valid && !out_stall)
        sb.check_outcome({hit, frame_slot, evicted_valid, evicted_page, miss_total, hit_total});
    end
  end

  task automatic issue_page(input logic [PAGE_W-1:0] p);
    in_valid <= 1'b1;
    page <= p;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0 || in_stall);
  endtask

  task automatic write_frame_count(input logic [FRAME_COUNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_frame_count(v);
  endtask

  task automatic run_phase(input logic [FRAME_COUNT_W-1:0] fc, input int beats);
    logic [PAGE_W-1:0] pool[16];
    int                pool_size;
    int                burst;
    bit                calm;
    int                sent;
    write_frame_count(fc);
    pool_size = $urandom_range((fc > 8 ? 8 : fc) + 3, 2);
    if (pool_size > 16) pool_size = 16;
    for (int i = 0; i < 16; i++) pool[i] = PAGE_W'($urandom_range(16'hffff));
    calm = ($urandom_range(3) == 0);
    sent = 0;
    while (sent < beats) begin
      burst = $urandom_range(16, 1);
      for (int b = 0; b < burst && sent < beats; b++) begin
        if ($urandom_range(9) < 8) issue_page(pool[$urandom_range(pool_size - 1)]);
        else issue_page(PAGE_W'($urandom_range(16'hffff)));
        sent++;
      end
      if (!calm) pause_sender($urandom_range(6, 1));
      if (sent == beats / 2 && $urandom_range(1)) drain();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default frame count after reset, fill all frames then evict
    issue_page(16'h0000);
    issue_page(16'hffff);
    issue_page(16'h0000);
    issue_page(16'h5555);
    issue_page(16'haaaa);
    issue_page(16'h0001);
    issue_page(16'h8000);
    issue_page(16'h1234);
    issue_page(16'h00ff);
    issue_page(16'hff00);
    issue_page(16'h0000);
    issue_page(16'h5555);
    issue_page(16'hffff);
    // single frame
    write_frame_count(4'd1);
    issue_page(16'h0042);
    issue_page(16'h0042);
    issue_page(16'h0043);
    // zero acts as one frame
    write_frame_count(4'd0);
    issue_page(16'h0007);
    issue_page(16'h0007);
    issue_page(16'h0009);
    // above capacity acts as capacity
    write_frame_count(4'd15);
    issue_page(16'h0100);
    issue_page(16'h0200);
    issue_page(16'h0100);
    // rewriting the same value still empties the frames
    write_frame_count(4'd15);
    issue_page(16'h0100);
    issue_page(16'h0200);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0: run_phase(4'd8, 100);
        1: run_phase(4'd1, 100);
        2: run_phase(4'd0, 100);
        3: run_phase(4'd15, 100);
        default: run_phase(FRAME_COUNT_W'($urandom_range(15)), 100);
      endcase
    end

    drain();
    repeat (MAX_FRAMES_DEF + 4) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end
endmodule
